@@ rtl/tprs_pkg.sv @@
// shared widths, codes and reset values for the tachometer speed tracker
package tprs_pkg;

	localparam int NumW    = 32;
	localparam int SpeedW  = 16;
	localparam int TimerW  = 16;
	localparam int OvfW    = 4;
	localparam int PeriodW = OvfW + TimerW;
	localparam int SumW    = 32;
	localparam int StepW   = 28;
	localparam int CfgIdxW = 2;

	localparam logic [CfgIdxW-1:0] REG_NUMERATOR = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_CEILING   = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_OVF_LIMIT = 2'd2;

	localparam logic REQ_PULSE    = 1'b0;
	localparam logic REQ_OVERFLOW = 1'b1;

	localparam logic [NumW-1:0]   NUMERATOR_RESET = 32'd60000000;
	localparam logic [SpeedW-1:0] CEILING_RESET   = 16'd15000;
	localparam logic [OvfW-1:0]   OVF_LIMIT_RESET = 4'd4;

	localparam int DiffShift = 3;
	localparam int SumShift  = 7;
	localparam int DeltaShift = 4;

	// handshake between the sequencer and a multi-cycle unit
	typedef struct packed {
		logic start;
		logic done;
	} unit_ctl_t;

endpackage

@@ rtl/tprs_if.sv @@
// request and response channel interfaces
interface tprs_req_if;
	logic                        valid;
	logic                        ready;
	logic                        req_type;
	logic [tprs_pkg::TimerW-1:0] timer_value;

	modport source (output valid, output req_type, output timer_value, input ready);
	modport sink (input valid, input req_type, input timer_value, output ready);
endinterface

interface tprs_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [tprs_pkg::SpeedW-1:0] speed;

	modport source (output valid, output speed, input ready);
	modport sink (input valid, input speed, output ready);
endinterface

@@ rtl/tprs_divider.sv @@
// bit-serial restoring divider, one quotient bit per cycle
module tprs_divider (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [tprs_pkg::NumW-1:0]      numerator,
	input  logic [tprs_pkg::PeriodW-1:0]   divisor,
	output logic                           done,
	output logic [tprs_pkg::NumW-1:0]      quotient
);
	import tprs_pkg::*;

	localparam int CntW = $clog2(NumW);

	logic [PeriodW-1:0] rem_q;
	logic [NumW-1:0]    quo_q;
	logic [PeriodW-1:0] den_q;
	logic [CntW-1:0]    cnt_q;
	logic               busy_q;
	logic               done_q;

	logic [PeriodW:0]   trial;
	logic [PeriodW+1:0] diff;
	logic               fits;

	assign trial = {rem_q, quo_q[NumW-1]};
	assign diff  = {1'b0, trial} - {2'b00, den_q};
	assign fits  = !diff[PeriodW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(NumW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= numerator;
			den_q <= divisor;
		end else if (busy_q) begin
			// remainder stays below the divisor, so it fits the divisor width
			rem_q <= fits ? diff[PeriodW-1:0] : trial[PeriodW-1:0];
			quo_q <= {quo_q[NumW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ rtl/tprs_pid.sv @@
// two-stage shift-based pid update of the tracked speed
module tprs_pid (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tprs_pkg::unit_ctl_t          ctl_in,
	input  logic [tprs_pkg::SpeedW-1:0]  raw,
	input  logic [tprs_pkg::SpeedW-1:0]  speed_in,
	output tprs_pkg::unit_ctl_t          ctl_out,
	output logic [tprs_pkg::SpeedW-1:0]  speed_out
);
	import tprs_pkg::*;

	logic signed [SumW-1:0]   error_sum_q;
	logic signed [SpeedW-1:0] last_error_q;

	logic signed [SpeedW-1:0] differ_s1;
	logic                     valid_s1;
	logic                     valid_s2;
	logic [SpeedW-1:0]        speed_s2;

	logic signed [SpeedW-1:0] differ;
	logic signed [SpeedW:0]   delta;
	logic signed [StepW-1:0]  step;
	logic signed [StepW-1:0]  next;

	assign differ = $signed(raw - speed_in);
	assign delta  = (SpeedW+1)'(differ_s1) - (SpeedW+1)'(last_error_q);

	always_comb begin
		step = (StepW'(differ_s1) >>> DiffShift)
		     + StepW'(error_sum_q >>> SumShift)
		     + (StepW'(delta) >>> DeltaShift);
		next = StepW'($signed({1'b0, speed_in})) + step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			error_sum_q  <= '0;
			last_error_q <= '0;
		end else begin
			valid_s1 <= ctl_in.start;
			valid_s2 <= valid_s1;
			if (ctl_in.start) begin
				error_sum_q <= error_sum_q + SumW'(differ);
			end
			if (valid_s1) begin
				last_error_q <= differ_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_in.start) begin
			differ_s1 <= differ;
		end
		if (valid_s1) begin
			// clamp to the unsigned speed range
			if (next[StepW-1]) begin
				speed_s2 <= '0;
			end else if (|next[StepW-2:SpeedW]) begin
				speed_s2 <= '1;
			end else begin
				speed_s2 <= next[SpeedW-1:0];
			end
		end
	end

	assign ctl_out.start = 1'b0;
	assign ctl_out.done  = valid_s2;
	assign speed_out     = speed_s2;

endmodule

@@ rtl/tacho_period_to_rpm_smoother.sv @@
// top level: tachometer period to smoothed rpm tracker
//
//  channel | dir | fields                    | accepted when
//  req     | in  | req_type, timer_value     | valid && ready
//  rsp     | out | speed                     | valid && ready
//  cfg     | in  | cfg_index, cfg_data       | cfg_wr_en
//
// an overflow tick or a zero period goes from the accept straight to the done
// state; a pulse runs the bit-serial divide and then the pid stages, skipping
// the pid when the quotient clamps or is zero, before the done state posts the
// result. one word is in flight at a time;
// the result register lets the next word be accepted while a result waits.
// reset clears the speed, the pid sums and the overflow count.
module tacho_period_to_rpm_smoother (
	input  logic                           clk,
	input  logic                           arst_n,
	tprs_req_if.sink                       req,
	tprs_rsp_if.source                     rsp,
	input  logic                           cfg_wr_en,
	input  logic [tprs_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [tprs_pkg::NumW-1:0]      cfg_data
);
	import tprs_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_PID  = 3'd2;
	localparam logic [2:0] ST_DONE = 3'd3;

	logic [2:0]        state_q;
	logic [NumW-1:0]   numerator_q;
	logic [SpeedW-1:0] ceiling_q;
	logic [OvfW-1:0]   limit_q;
	logic [OvfW-1:0]   ovf_count_q;
	logic [SpeedW-1:0] tracked_q;
	logic [SpeedW-1:0] raw_q;
	logic              out_valid_q;
	logic [SpeedW-1:0] out_speed_q;

	logic [PeriodW-1:0] period;
	logic [OvfW:0]      ovf_next;
	logic               take;
	logic               out_free;
	logic               div_start;
	logic               div_done;
	logic [NumW-1:0]    quotient;
	unit_ctl_t          pid_in;
	unit_ctl_t          pid_out;
	logic [SpeedW-1:0]  pid_speed;

	assign period   = {ovf_count_q, req.timer_value};
	assign ovf_next = {1'b0, ovf_count_q} + 1'b1;
	assign req.ready = (state_q == ST_IDLE);
	assign take     = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;
	assign div_start = take && (req.req_type == REQ_PULSE) && (period != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			numerator_q <= NUMERATOR_RESET;
			ceiling_q   <= CEILING_RESET;
			limit_q     <= OVF_LIMIT_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_NUMERATOR: numerator_q <= cfg_data;
				REG_CEILING:   ceiling_q   <= cfg_data[SpeedW-1:0];
				REG_OVF_LIMIT: limit_q     <= cfg_data[OvfW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ovf_count_q <= '0;
			tracked_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						state_q <= ST_DONE;
						if (req.req_type == REQ_OVERFLOW) begin
							if (ovf_next > {1'b0, limit_q}) begin
								tracked_q   <= '0;
								ovf_count_q <= '0;
							end else begin
								ovf_count_q <= ovf_next[OvfW-1:0];
							end
						end else begin
							ovf_count_q <= '0;
							if (period == '0) begin
								tracked_q <= ceiling_q;
							end else begin
								state_q <= ST_DIV;
							end
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						if (quotient > NumW'(ceiling_q)) begin
							tracked_q <= ceiling_q;
							state_q   <= ST_DONE;
						end else if (quotient == '0) begin
							tracked_q <= '0;
							state_q   <= ST_DONE;
						end else begin
							state_q <= ST_PID;
						end
					end
				end
				ST_PID: begin
					if (pid_out.done) begin
						tracked_q <= pid_speed;
						state_q   <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DIV && div_done) begin
			raw_q <= quotient[SpeedW-1:0];
		end
		if (state_q == ST_DONE && out_free) begin
			out_speed_q <= tracked_q;
		end
	end

	// pid starts in the same cycle that the quotient lands in raw_q
	logic pid_go_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pid_go_q <= 1'b0;
		end else begin
			pid_go_q <= (state_q == ST_DIV) && div_done && (quotient != '0)
			          && (quotient <= NumW'(ceiling_q));
		end
	end

	assign pid_in.start = pid_go_q;
	assign pid_in.done  = 1'b0;

	tprs_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.numerator (numerator_q),
		.divisor   (period),
		.done      (div_done),
		.quotient  (quotient)
	);

	tprs_pid u_pid (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_in    (pid_in),
		.raw       (raw_q),
		.speed_in  (tracked_q),
		.ctl_out   (pid_out),
		.speed_out (pid_speed)
	);

	assign rsp.valid = out_valid_q;
	assign rsp.speed = out_speed_q;

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

	a_pid_done_in_pid: assert property (@(posedge clk) disable iff (!arst_n)
		pid_out.done |-> state_q == ST_PID)
		else $error("pid finished outside the pid state");

	a_pulse_divides: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> state_q == ST_DIV)
		else $error("pulse with nonzero period did not start a divide");

	a_result_posted: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("finished word was not posted to the result register");

endmodule
